>>> rtl/pbb_pkg.sv
// ---------------------------------------------------------------------------
// pbb_pkg
// shared constants and types of the page bitmap blit: register indexes,
// frame store geometry and the beats passed between the blit stages
// ---------------------------------------------------------------------------
`default_nettype none

package pbb_pkg;

   // frame store geometry
   localparam int STORE_DEPTH = 1024;
   localparam int STORE_AW    = 10;
   localparam int BYTE_W      = 8;

   // default frame size in pixels
   localparam int FRAME_COLUMNS_DEF = 128;
   localparam int FRAME_ROWS_DEF    = 64;

   // width of the unclipped frame address sum (page * columns + column)
   localparam int ADDR_CALC_W = 14;

   // configuration register indexes
   localparam int CSR_IW = 3;
   localparam logic [CSR_IW-1:0] CSR_ORIGIN_X        = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ORIGIN_Y        = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_BITMAP_WIDTH    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_BITMAP_HEIGHT   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_INVERT_PIXELS   = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_VERTICAL_OFFSET = 3'd5;

   // command codes
   localparam logic CMD_BLIT = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic [7:0] origin_x;
      logic [7:0] origin_y;
      logic [7:0] bitmap_width;
      logic [7:0] bitmap_height;
      logic       invert_pixels;
      logic [7:0] vertical_offset;
   } cfg_type;

   // one accepted beat entering the blit stages
   typedef struct packed {
      logic                is_read;
      logic [STORE_AW-1:0] read_address;
      logic [7:0]          source_byte;
      logic [4:0]          band;
      logic [7:0]          column;
   } item_type;

   // up to two read-modify-writes, or one plain read
   typedef struct packed {
      logic                is_read;
      logic [STORE_AW-1:0] addr0;
      logic [7:0]          data0;
      logic                en0;
      logic [STORE_AW-1:0] addr1;
      logic [7:0]          data1;
      logic                en1;
   } job_type;

endpackage

`default_nettype wire

>>> rtl/pbb_ram.sv
// ---------------------------------------------------------------------------
// pbb_ram
// generic memory: one write port, one read port, registered read data
// (read during write to the same entry returns the old contents)
// ---------------------------------------------------------------------------
`default_nettype none

module pbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/pbb_calc.sv
// ---------------------------------------------------------------------------
// pbb_calc
// geometry stages of the blit: turns one column byte into at most two
// masked and shifted page writes, or passes a read through
// ---------------------------------------------------------------------------
`default_nettype none

module pbb_calc #(
   parameter int FRAME_COLUMNS = pbb_pkg::FRAME_COLUMNS_DEF,
   parameter int FRAME_ROWS    = pbb_pkg::FRAME_ROWS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pbb_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire pbb_pkg::item_type in_item,
   output logic                   job_valid,
   input  wire logic              job_pop,
   output pbb_pkg::job_type       job
);

   localparam int AW = pbb_pkg::STORE_AW;
   localparam int CW = pbb_pkg::ADDR_CALC_W;

   // stage a: column, start row and bottom edge
   logic          a_valid_ff;
   logic          a_is_read_ff;
   logic [AW-1:0] a_raddr_ff;
   logic [7:0]    a_pix_ff, a_xx_ff, a_y_ff, a_bottom_ff, a_oy_ff;
   logic          a_x_out_ff, a_voff_nz_ff;
   logic [4:0]    a_band_ff;
   logic [7:0]    a_xx_in;

   // stage b: rows, clipping and mask cases
   logic          b_valid_ff;
   logic          b_is_read_ff;
   logic [AW-1:0] b_raddr_ff;
   logic [7:0]    b_pix_ff, b_xx_ff, b_top_ff, b_next_ff, b_n_lo_ff, b_n_hi_ff;
   logic          b_skip_ff, b_voff_nz_ff, b_lo_case_ff, b_hi_case_ff;
   logic          b_top_in_ff, b_next_in_ff;
   logic [7:0]    b_top_in, b_next_in;
   logic          b_clip_in;

   // stage c: the job
   logic              c_valid_ff;
   pbb_pkg::job_type  c_job_ff;
   pbb_pkg::job_type  c_job_in;
   logic [7:0]        mask, masked;
   logic [15:0]       spread;
   logic [CW-1:0]     sum0, sum1;

   logic a_move, a_free, b_move, b_free, c_free;

   assign c_free   = !c_valid_ff || job_pop;
   assign b_move   = b_valid_ff && c_free;
   assign b_free   = !b_valid_ff || b_move;
   assign a_move   = a_valid_ff && b_free;
   assign a_free   = !a_valid_ff || a_move;
   assign in_ready = a_free;

   assign job_valid = c_valid_ff;
   assign job       = c_job_ff;

   // stage a
   assign a_xx_in = in_item.column + cfg.origin_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (in_valid && a_free) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_free) begin
         a_is_read_ff <= in_item.is_read;
         a_raddr_ff   <= in_item.read_address;
         a_pix_ff     <= cfg.invert_pixels ? ~in_item.source_byte : in_item.source_byte;
         a_xx_ff      <= a_xx_in;
         a_x_out_ff   <= {1'b0, a_xx_in} >= 9'(FRAME_COLUMNS);
         a_y_ff       <= cfg.origin_y - cfg.vertical_offset;
         a_bottom_ff  <= cfg.origin_y + cfg.bitmap_height;
         a_oy_ff      <= cfg.origin_y;
         a_voff_nz_ff <= cfg.vertical_offset != 8'd0;
         a_band_ff    <= in_item.band;
      end
   end

   // stage b
   assign b_top_in  = {a_band_ff, 3'b000} + a_y_ff;
   assign b_next_in = b_top_in + 8'd8;
   assign b_clip_in = a_voff_nz_ff && ((b_next_in < a_oy_ff)
                      || ({1'b0, b_next_in} > 9'(FRAME_ROWS))
                      || (b_top_in > a_bottom_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (a_move) begin
         b_valid_ff <= 1'b1;
      end else if (b_move) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_is_read_ff <= a_is_read_ff;
         b_raddr_ff   <= a_raddr_ff;
         b_pix_ff     <= a_pix_ff;
         b_xx_ff      <= a_xx_ff;
         b_top_ff     <= b_top_in;
         b_next_ff    <= b_next_in;
         b_skip_ff    <= a_x_out_ff || b_clip_in;
         b_voff_nz_ff <= a_voff_nz_ff;
         b_lo_case_ff <= b_top_in < a_oy_ff;
         b_hi_case_ff <= b_next_in > a_bottom_ff;
         b_n_lo_ff    <= a_oy_ff - b_top_in;
         b_n_hi_ff    <= b_next_in - a_bottom_ff;
         b_top_in_ff  <= {1'b0, b_top_in} < 9'(FRAME_ROWS);
         b_next_in_ff <= {1'b0, b_next_in} < 9'(FRAME_ROWS);
      end
   end

   // stage c: mask, split across pages, page addresses
   always_comb begin
      mask = 8'hFF;
      if (b_voff_nz_ff) begin
         priority if (b_lo_case_ff) begin
            mask = (b_n_lo_ff >= 8'd8) ? 8'h00 : (8'hFF << b_n_lo_ff[2:0]);
         end else if (b_hi_case_ff) begin
            mask = (b_n_hi_ff >= 8'd8) ? 8'h00 : (8'hFF >> b_n_hi_ff[2:0]);
         end else begin
            mask = 8'hFF;
         end
      end
   end

   assign masked = b_pix_ff & mask;
   // start row bits 2:0 equal the sub-page shift, since bands step by eight rows
   assign spread = {8'h00, masked} << b_top_ff[2:0];
   assign sum0   = CW'(b_xx_ff) + CW'(b_top_ff[7:3]) * CW'(FRAME_COLUMNS);
   assign sum1   = CW'(b_xx_ff) + CW'(b_next_ff[7:3]) * CW'(FRAME_COLUMNS);

   always_comb begin
      c_job_in.is_read = b_is_read_ff;
      if (b_is_read_ff) begin
         c_job_in.addr0 = b_raddr_ff;
      end else begin
         c_job_in.addr0 = sum0[AW-1:0];
      end
      c_job_in.data0 = spread[7:0];
      c_job_in.en0   = !b_is_read_ff && !b_skip_ff && b_top_in_ff
                       && (spread[7:0] != 8'h00) && (sum0 < CW'(pbb_pkg::STORE_DEPTH));
      c_job_in.addr1 = sum1[AW-1:0];
      c_job_in.data1 = spread[15:8];
      c_job_in.en1   = !b_is_read_ff && !b_skip_ff && b_next_in_ff
                       && (spread[15:8] != 8'h00) && (sum1 < CW'(pbb_pkg::STORE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (b_move) begin
         c_valid_ff <= 1'b1;
      end else if (job_pop) begin
         c_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         c_job_ff <= c_job_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/page_bitmap_blit_top.sv
// ---------------------------------------------------------------------------
// page_bitmap_blit_top
// ORs monochrome bitmap column bytes into a page-organised frame store and
// reads stored bytes back
// ---------------------------------------------------------------------------
// usage
//   req_: one beat per command. cmd blit takes the next column byte of the
//     bitmap (band by band, left to right); cmd read returns one frame byte.
//   rsp_: one beat per read command, in command order. blit beats give none.
//   csr_: register writes, accepted every cycle; any write restarts the
//     column and band counters. write only while the block is idle.
// read path: a read beat passes the three geometry stages, the memory read
//   and the output register before rsp_valid rises.
// issue: one issue slot into the single-write-port store per cycle.
//   a blit beat takes one slot per page it touches (one or two), one that
//   writes nothing one, one past the bitmap none; no two reads in a row.
// reset: the frame store is cleared by a sweep over all 1024 entries, one
//   entry a cycle; req_ready stays low until it ends.
// stall: a held rsp_ beat holds back later reads; blit beats keep flowing
//   until the geometry stages fill up.
// ---------------------------------------------------------------------------
`default_nettype none

module page_bitmap_blit_top #(
   parameter int FRAME_COLUMNS = pbb_pkg::FRAME_COLUMNS_DEF,
   parameter int FRAME_ROWS    = pbb_pkg::FRAME_ROWS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // command channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_cmd,
   input  wire logic [7:0]                 req_source_byte,
   input  wire logic [9:0]                 req_read_address,
   // read data channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [7:0]                 rsp_read_data,
   // register write channel
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [pbb_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [7:0]                 csr_wdata
);

   localparam int AW = pbb_pkg::STORE_AW;

   // registers
   pbb_pkg::cfg_type cfg_ff;
   logic [7:0]       col_ff;
   logic [4:0]       band_ff;

   // clearing sweep
   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;

   // geometry stages
   logic              calc_in_valid, calc_in_ready;
   pbb_pkg::item_type calc_item;
   logic              job_valid, job_pop;
   pbb_pkg::job_type  job;

   // issue slot
   logic          op0_done_ff;
   logic          iss_en, iss_rd, iss_op0;
   logic [AW-1:0] iss_addr;
   logic [7:0]    iss_data;
   logic          pend0, pend1, rd_gate;

   // return cycle of an issued read
   logic          ret_v_ff, ret_rd_ff;
   logic [AW-1:0] ret_addr_ff;
   logic [7:0]    ret_data_ff;
   logic [7:0]    ram_rdata, merged;

   // last write, for forwarding into a read that missed it
   logic          lw_v_ff;
   logic [AW-1:0] lw_addr_ff;
   logic [7:0]    lw_data_ff;

   // memory write port
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   logic req_take, blit_live;
   logic [8:0] col_next;

   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // register file; any write restarts the bitmap position
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            pbb_pkg::CSR_ORIGIN_X:        cfg_ff.origin_x        <= csr_wdata;
            pbb_pkg::CSR_ORIGIN_Y:        cfg_ff.origin_y        <= csr_wdata;
            pbb_pkg::CSR_BITMAP_WIDTH:    cfg_ff.bitmap_width    <= csr_wdata;
            pbb_pkg::CSR_BITMAP_HEIGHT:   cfg_ff.bitmap_height   <= csr_wdata;
            pbb_pkg::CSR_INVERT_PIXELS:   cfg_ff.invert_pixels   <= csr_wdata[0];
            pbb_pkg::CSR_VERTICAL_OFFSET: cfg_ff.vertical_offset <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // command intake and bitmap position
   // ---------------------------------------------------------------------
   assign req_ready = !clr_ff && calc_in_ready;
   assign req_take  = req_valid && req_ready;
   // bytes past the last band, or with no columns, are dropped here
   assign blit_live = (cfg_ff.bitmap_width != 8'd0) && (band_ff < cfg_ff.bitmap_height[7:3]);
   assign col_next  = {1'b0, col_ff} + 9'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         band_ff <= '0;
      end else if (csr_valid) begin
         col_ff  <= '0;
         band_ff <= '0;
      end else if (req_take && (req_cmd == pbb_pkg::CMD_BLIT) && blit_live) begin
         if (col_next >= {1'b0, cfg_ff.bitmap_width}) begin
            col_ff  <= '0;
            band_ff <= band_ff + 5'd1;
         end else begin
            col_ff <= col_next[7:0];
         end
      end
   end

   assign calc_in_valid = req_valid && !clr_ff
                          && ((req_cmd == pbb_pkg::CMD_READ) || blit_live);

   always_comb begin
      calc_item.is_read      = req_cmd == pbb_pkg::CMD_READ;
      calc_item.read_address = req_read_address;
      calc_item.source_byte  = req_source_byte;
      calc_item.band         = band_ff;
      calc_item.column       = col_ff;
   end

   pbb_calc #(
      .FRAME_COLUMNS (FRAME_COLUMNS),
      .FRAME_ROWS    (FRAME_ROWS)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (calc_in_valid),
      .in_ready  (calc_in_ready),
      .in_item   (calc_item),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job       (job)
   );

   // ---------------------------------------------------------------------
   // issue: one store read per cycle, first page before second page
   // ---------------------------------------------------------------------
   assign pend0 = job.en0 && !op0_done_ff;
   assign pend1 = job.en1;
   // a read may go only if the output register is free when its data returns
   assign rd_gate = !(ret_v_ff && ret_rd_ff) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      iss_en   = 1'b0;
      iss_rd   = 1'b0;
      iss_op0  = 1'b0;
      iss_addr = job.addr0;
      iss_data = job.data0;
      job_pop  = 1'b0;
      if (job_valid && !clr_ff) begin
         priority if (job.is_read) begin
            if (rd_gate) begin
               iss_en  = 1'b1;
               iss_rd  = 1'b1;
               job_pop = 1'b1;
            end
         end else if (pend0) begin
            iss_en  = 1'b1;
            iss_op0 = 1'b1;
            job_pop = !pend1;
         end else if (pend1) begin
            iss_en   = 1'b1;
            iss_addr = job.addr1;
            iss_data = job.data1;
            job_pop  = 1'b1;
         end else begin
            // clipped or empty byte: nothing to write
            job_pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op0_done_ff <= 1'b0;
      end else if (job_pop) begin
         op0_done_ff <= 1'b0;
      end else if (iss_op0) begin
         op0_done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ret_v_ff <= 1'b0;
      end else begin
         ret_v_ff <= iss_en;
      end
   end

   always_ff @(posedge clock) begin
      ret_rd_ff   <= iss_rd;
      ret_addr_ff <= iss_addr;
      ret_data_ff <= iss_data;
   end

   // ---------------------------------------------------------------------
   // frame store with read-modify-write
   // ---------------------------------------------------------------------
   pbb_ram #(
      .WIDTH (pbb_pkg::BYTE_W),
      .DEPTH (pbb_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (iss_addr),
      .rd_data (ram_rdata)
   );

   // the write of the previous cycle landed after this read was taken
   assign merged = (lw_v_ff && (lw_addr_ff == ret_addr_ff)) ? lw_data_ff : ram_rdata;

   assign wr_en   = clr_ff || (ret_v_ff && !ret_rd_ff);
   assign wr_addr = clr_ff ? clr_cnt_ff : ret_addr_ff;
   assign wr_data = clr_ff ? 8'h00 : (merged | ret_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_v_ff <= 1'b0;
      end else begin
         lw_v_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      lw_addr_ff <= wr_addr;
      lw_data_ff <= wr_data;
   end

   // clearing sweep after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(pbb_pkg::STORE_DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // read data beat
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ret_v_ff && ret_rd_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ret_v_ff && ret_rd_ff) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the page bitmap blit: programs bitmap geometry over
// the register port, streams column bytes and read commands with random gaps
// and result back-pressure, and compares every read beat against a local
// frame store image kept up to date beat by beat
// ---------------------------------------------------------------------------

module tb_top;

   import pbb_pkg::*;

   // frame geometry of the instance under test
   localparam int FRAME_COLS = FRAME_COLUMNS_DEF;
   localparam int FRAME_ROWS = FRAME_ROWS_DEF;

   // register indexes past the end of the list: they only restart the counters
   localparam logic [CSR_IW-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IW-1:0] CSR_SPARE_B = 3'd7;

   // cycles to let the geometry stages and the store drain before a register
   // write (blit beats leave no result to wait for)
   localparam int DRAIN_CYCLES = 16;

   // number of working beats in the random part
   localparam int RANDOM_ITEMS = 700;

   // about 1800 beats, each at worst with the longest sender gap, result
   // stall and both page writes, plus the clearing sweep and the register
   // phases, fit well inside this bound
   localparam int CYCLE_LIMIT = 1_000_000;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // command channel
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic       req_cmd          = CMD_BLIT;
   logic [7:0] req_source_byte  = 8'h00;
   logic [9:0] req_read_address = 10'h000;

   // read data channel
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [7:0] rsp_read_data;

   // register write channel
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = CSR_ORIGIN_X;
   logic [7:0]        csr_wdata = 8'h00;

   // local copy of the block: frame store image, position counters, registers
   logic [7:0] store_image [STORE_DEPTH] = '{default: 8'h00};
   logic [7:0] col_pos    = 8'd0;
   logic [4:0] band_pos   = 5'd0;
   cfg_type    shadow_cfg = '0;

   // read data owed by the block, oldest first
   logic [7:0] read_data_due [$];

   // bookkeeping
   int         cycle_count     = 0;
   int         mismatches      = 0;
   int         effective_beats = 0;
   int         rsp_stall_left  = 0;
   logic [7:0] due_byte;

   // idling switches, changed per phase by the tests
   bit sender_gaps = 1'b1;
   bit rsp_stalls  = 1'b1;

   page_bitmap_blit_top #(
      .FRAME_COLUMNS (FRAME_COLS),
      .FRAME_ROWS    (FRAME_ROWS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_source_byte  (req_source_byte),
      .req_read_address (req_read_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // single reset pulse at the start
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("page_bitmap_blit_top regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // frame store image
   // ------------------------------------------------------------------------

   // OR a byte into the image, dropping anything past the store
   function automatic void or_into_store(input int addr, input int value);
      if (addr < STORE_DEPTH)
         store_image[addr] = store_image[addr] | 8'(value);
   endfunction

   // place one column byte of the bitmap at (band, col)
   function automatic void draw_column_byte(input logic [7:0] src, input int band,
                                            input int col);
      int yy, y, shift, bottom, top_row, next_row, n, xx, pix, mask, page0, page1;
      yy       = shadow_cfg.origin_y;
      // all row sums wrap at 8 bits
      y        = (yy - int'(shadow_cfg.vertical_offset)) & 255;
      shift    = y % 8;
      bottom   = (yy + int'(shadow_cfg.bitmap_height)) & 255;
      top_row  = (band * 8 + y) & 255;
      next_row = (top_row + 8) & 255;
      mask     = 255;
      // a scrolled bitmap is clipped band by band and masked at its edges
      if (shadow_cfg.vertical_offset != 0) begin
         if (next_row < yy || next_row > FRAME_ROWS || top_row > bottom)
            return;
         if (top_row < yy) begin
            n    = yy - top_row;
            mask = (n >= 8) ? 0 : ((255 << n) & 255);
         end else if (next_row > bottom) begin
            n    = next_row - bottom;
            mask = (n >= 8) ? 0 : (255 >> n);
         end
      end
      xx = (col + int'(shadow_cfg.origin_x)) & 255;
      if (xx >= FRAME_COLS)
         return;
      pix   = shadow_cfg.invert_pixels ? (~int'(src) & 255) : int'(src);
      pix   = pix & mask;
      page0 = (top_row / 8) * FRAME_COLS;
      page1 = (next_row / 8) * FRAME_COLS;
      if (shift == 0 && top_row < FRAME_ROWS) begin
         or_into_store(xx + page0, pix);
      end else begin
         // straddles two pages, either half may fall below the frame
         if (top_row < FRAME_ROWS)
            or_into_store(xx + page0, (pix << shift) & 255);
         if (next_row < FRAME_ROWS)
            or_into_store(xx + page1, (pix >> (8 - shift)) & 255);
      end
   endfunction

   // effect of one accepted command beat on the image and the owed reads
   function automatic void apply_command(input logic cmd, input logic [7:0] src,
                                         input logic [9:0] addr);
      int bands;
      bands = shadow_cfg.bitmap_height / 8;
      if (cmd == CMD_READ) begin
         read_data_due.push_back(store_image[addr]);
         effective_beats++;
         return;
      end
      // bytes past the bitmap, or into an empty one, leave everything as is
      if (shadow_cfg.bitmap_width == 0 || int'(band_pos) >= bands)
         return;
      effective_beats++;
      draw_column_byte(src, band_pos, col_pos);
      if (int'(col_pos) + 1 >= int'(shadow_cfg.bitmap_width)) begin
         col_pos  = 8'd0;
         band_pos = band_pos + 5'd1;
      end else begin
         col_pos = col_pos + 8'd1;
      end
   endfunction

   // register write: any index restarts the counters, spare ones change nothing else
   function automatic void apply_register(input logic [CSR_IW-1:0] idx,
                                          input logic [7:0] value);
      case (idx)
         CSR_ORIGIN_X:        shadow_cfg.origin_x        = value;
         CSR_ORIGIN_Y:        shadow_cfg.origin_y        = value;
         CSR_BITMAP_WIDTH:    shadow_cfg.bitmap_width    = value;
         CSR_BITMAP_HEIGHT:   shadow_cfg.bitmap_height   = value;
         CSR_INVERT_PIXELS:   shadow_cfg.invert_pixels   = value[0];
         CSR_VERTICAL_OFFSET: shadow_cfg.vertical_offset = value;
         default: ;
      endcase
      col_pos  = 8'd0;
      band_pos = 5'd0;
   endfunction

   // ------------------------------------------------------------------------
   // result side: random back-pressure and the read data check
   // ------------------------------------------------------------------------

   // mostly short stalls, now and then a long one; no new ones when switched off
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 99) < 20) begin
         rsp_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // every read beat is matched against the oldest owed byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (read_data_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("cycle %0d: read data beat %02h with no read outstanding",
                        cycle_count, rsp_read_data);
         end else begin
            due_byte = read_data_due.pop_front();
            if (rsp_read_data !== due_byte) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("cycle %0d: read_data expected %02h got %02h",
                           cycle_count, due_byte, rsp_read_data);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // command and register drivers
   // ------------------------------------------------------------------------

   // one command beat; valid stays up afterwards so back-to-back beats need
   // no drop, it is lowered only ahead of a gap or by wait_idle
   task automatic send_command(input logic cmd, input logic [7:0] src,
                               input logic [9:0] addr);
      int gap;
      int r;
      gap = 0;
      if (sender_gaps) begin
         r = $urandom_range(0, 99);
         if (r >= 97)
            gap = $urandom_range(10, 30);
         else if (r >= 88)
            gap = $urandom_range(4, 8);
         else if (r >= 55)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_source_byte  <= src;
      req_read_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_command(cmd, src, addr);
   endtask

   // quiet the command channel, collect every owed read, let the pipe drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (read_data_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write, only ever issued with the block idle
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [7:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_bitmap(input logic [7:0] ox, input logic [7:0] oy,
                                 input logic [7:0] w, input logic [7:0] h,
                                 input logic inv, input logic [7:0] off);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_BITMAP_WIDTH, w);
      write_reg(CSR_BITMAP_HEIGHT, h);
      write_reg(CSR_INVERT_PIXELS, {7'($urandom), inv});
      write_reg(CSR_VERTICAL_OFFSET, off);
   endtask

   // mostly the range that lands on the frame, sometimes the extremes
   function automatic logic [7:0] pick_reg_value(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 78)
         return 8'($urandom_range(lo, hi));
      else if (r < 86)
         return 8'h00;
      else if (r < 94)
         return 8'hFF;
      else
         return 8'($urandom);
   endfunction

   // half the reads aim at the columns just drawn, half anywhere in the store
   function automatic logic [9:0] pick_read_address(input logic [7:0] ox,
                                                    input logic [7:0] w);
      int col;
      if ($urandom_range(0, 1) == 0)
         return 10'($urandom);
      col = (int'(ox) + $urandom_range(0, (w > 16) ? 16 : int'(w))) % FRAME_COLS;
      return 10'($urandom_range(0, 7) * FRAME_COLS + col);
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // cleared store, and a column byte into a bitmap of zero width
   task automatic test_reset_state();
      send_command(CMD_BLIT, 8'hFF, 10'd0);
      send_command(CMD_READ, 8'h00, 10'd0);
      send_command(CMD_READ, 8'hFF, 10'd1023);
   endtask

   // page aligned two-band bitmap, then a byte past its end
   task automatic test_aligned_blit();
      program_bitmap(8'd0, 8'd0, 8'd2, 8'd16, 1'b0, 8'd0);
      send_command(CMD_BLIT, 8'hFF, 10'd0);
      send_command(CMD_BLIT, 8'h00, 10'd1023);
      send_command(CMD_BLIT, 8'h81, 10'd0);
      send_command(CMD_BLIT, 8'h7E, 10'd0);
      send_command(CMD_BLIT, 8'h55, 10'd0);
      send_command(CMD_READ, 8'h00, 10'd0);
      send_command(CMD_READ, 8'h00, 10'd128);
      send_command(CMD_READ, 8'h00, 10'd129);
   endtask

   // writes to the spare indexes restart the counters: all bytes hit column 0
   task automatic test_counter_restart();
      program_bitmap(8'd8, 8'd0, 8'd3, 8'd8, 1'b0, 8'd0);
      send_command(CMD_BLIT, 8'h01, 10'd0);
      write_reg(CSR_SPARE_A, 8'hA5);
      send_command(CMD_BLIT, 8'h02, 10'd0);
      write_reg(CSR_SPARE_B, 8'h5A);
      send_command(CMD_BLIT, 8'h04, 10'd0);
      send_command(CMD_READ, 8'h00, 10'd8);
   endtask

   // inverted bytes straddling the bottom page, last column off the frame
   task automatic test_bottom_edge();
      program_bitmap(8'd126, 8'd60, 8'd3, 8'd8, 1'b1, 8'd0);
      send_command(CMD_BLIT, 8'hF0, 10'd0);
      send_command(CMD_BLIT, 8'h00, 10'd0);
      send_command(CMD_BLIT, 8'hFF, 10'd0);
      send_command(CMD_READ, 8'h00, 10'd1022);
      send_command(CMD_READ, 8'h00, 10'd1023);
   endtask

   // scrolled bitmap: first band clipped away, second split over two pages
   task automatic test_scroll_clip();
      program_bitmap(8'd40, 8'd0, 8'd1, 8'd16, 1'b0, 8'd4);
      send_command(CMD_BLIT, 8'hFF, 10'd0);
      send_command(CMD_BLIT, 8'hFF, 10'd0);
      send_command(CMD_READ, 8'h00, 10'd40);
      send_command(CMD_READ, 8'h00, 10'd168);
   endtask

   // bottom mask shifted by a full byte writes nothing
   task automatic test_mask_overshift();
      program_bitmap(8'd50, 8'd0, 8'd1, 8'd8, 1'b0, 8'd248);
      send_command(CMD_BLIT, 8'hFF, 10'd0);
      send_command(CMD_READ, 8'h00, 10'd50);
   endtask

   // random bitmaps fed whole, with reads mixed in and read back afterwards
   task automatic test_random_bitmaps();
      int         start_count;
      int         bands;
      int         feed;
      int         i;
      int         r;
      logic [7:0] ox, oy, w, h, off, src;
      logic       inv;
      start_count = effective_beats;
      while (effective_beats - start_count < RANDOM_ITEMS) begin
         // about one phase in four runs without any idling on a side
         sender_gaps = ($urandom_range(0, 3) != 0);
         rsp_stalls  = ($urandom_range(0, 3) != 0);
         ox  = pick_reg_value(0, 127);
         oy  = pick_reg_value(0, 63);
         w   = pick_reg_value(1, 12);
         h   = pick_reg_value(8, 40);
         inv = 1'($urandom_range(0, 1));
         off = ($urandom_range(0, 1) != 0) ? 8'd0 : pick_reg_value(1, 24);
         program_bitmap(ox, oy, w, h, inv, off);
         bands = h / 8;
         feed  = int'(w) * bands;
         // wide bitmaps are only fed in part, small ones get a few bytes past the end
         if (feed > 48)
            feed = 48;
         else
            feed += $urandom_range(0, 2);
         for (i = 0; i < feed; i++) begin
            if ($urandom_range(0, 99) < 25)
               send_command(CMD_READ, 8'($urandom), pick_read_address(ox, w));
            if (i == feed / 2 && $urandom_range(0, 7) == 0)
               write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 8'($urandom));
            // sparse marks keep the store from filling up with ones
            r = $urandom_range(0, 99);
            if (r < 55)
               src = 8'(1 << $urandom_range(0, 7));
            else if (r < 75)
               src = 8'(1 << $urandom_range(0, 7)) | 8'(1 << $urandom_range(0, 7));
            else if (r < 85)
               src = 8'h00;
            else if (r < 90)
               src = 8'hFF;
            else
               src = 8'($urandom);
            if (inv)
               src = ~src;
            send_command(CMD_BLIT, src, 10'($urandom));
         end
         repeat ($urandom_range(2, 6))
            send_command(CMD_READ, 8'($urandom), pick_read_address(ox, w));
      end
   endtask

   // sweep the whole store
   task automatic test_store_readback();
      int a;
      sender_gaps = 1'b1;
      rsp_stalls  = 1'b1;
      for (a = 0; a < STORE_DEPTH; a++)
         send_command(CMD_READ, 8'($urandom), 10'(a));
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin
      while (reset) @(posedge clock);
      test_reset_state();
      test_aligned_blit();
      test_counter_restart();
      test_bottom_edge();
      test_scroll_clip();
      test_mask_overshift();
      test_random_bitmaps();
      test_store_readback();
      wait_idle();
      if (mismatches == 0 && read_data_due.size() == 0) begin
         $display("page_bitmap_blit_top regression: pass");
      end else begin
         $display("page_bitmap_blit_top regression: fail");
      end
      $finish;
   end

endmodule
